// File: rtl/sst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set table package
// Sizes, codes and control structures shared by the sorted set table files.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    typedef enum logic [1:0] {
        OP_INSERT    = 2'd0,
        OP_DELETE    = 2'd1,
        OP_DUMP_ASC  = 2'd2,
        OP_DUMP_DESC = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_INSERTED  = 3'd0,
        KIND_DUPLICATE = 3'd1,
        KIND_DELETED   = 3'd2,
        KIND_NOTFOUND  = 3'd3,
        KIND_FULL      = 3'd4,
        KIND_ENTRY     = 3'd5,
        KIND_EMPTY     = 3'd6
    } kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DUMP = 1'b1
    } state_t;

    typedef struct packed {
        logic                    ins_en;
        logic                    del_en;
        logic signed [VAL_W-1:0] key;
        logic [IDX_W-1:0]        rd_idx;
        logic [CNT_W-1:0]        count;
    } cmd_t;

    typedef struct packed {
        logic                    any_eq;
        logic signed [VAL_W-1:0] rd_value;
    } stat_t;

endpackage

// File: rtl/sst_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set table request channel
// Valid/ready channel carrying one operation and its key per beat.
// ----------------------------------------------------------------------------
interface sst_req_if;
    logic                            valid;
    logic                            ready;
    sst_pkg::op_t                    op;
    logic signed [sst_pkg::VAL_W-1:0] key_value;

    modport source (output valid, output op, output key_value, input ready);
    modport sink   (input valid, input op, input key_value, output ready);
endinterface

// File: rtl/sst_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set table response channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface sst_rsp_if;
    logic                             valid;
    logic                             ready;
    sst_pkg::kind_t                   kind;
    logic signed [sst_pkg::VAL_W-1:0] entry_value;
    logic                             last;

    modport source (output valid, output kind, output entry_value, output last, input ready);
    modport sink   (input valid, input kind, input entry_value, input last, output ready);
endinterface

// File: rtl/sorted_set_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set table
// A set of distinct signed 32-bit values kept in ascending order in a row of
// cells, with insert, delete and ordered dump operations.
//
// Requests arrive on req: op (insert, delete, dump ascending, dump
// descending) and key_value. Results leave on rsp as kind, entry_value and
// last, where last marks the final beat caused by a request.
// An insert or delete is compared against every cell at once and updates
// the whole row in the cycle it is accepted; its single status beat shows
// on rsp in the next cycle.
// A dump gives one beat per stored entry, one per cycle while rsp is not
// stalled, read from the row through the entry selector, then the next
// request is taken; an empty table gives a single empty beat. A non-empty
// dump keeps req.ready low while it runs, and its first beat passes through
// the dump state and then the output register before it shows on rsp.
// The output register lets a new request in while the previous result is
// being taken; while rsp is stalled nothing moves and req.ready stays low.
// Reset empties the table at once; stale cell contents are never read.
// ----------------------------------------------------------------------------
module sorted_set_table (
    input  logic      clk,
    input  logic      rst_n,
    sst_req_if.sink   req,
    sst_rsp_if.source rsp
);

    sst_pkg::cmd_t cmd;
    sst_pkg::stat_t stat;

    logic [sst_pkg::CAPACITY-1:0]     lt;
    logic [sst_pkg::CAPACITY-1:0]     eq;
    logic [sst_pkg::CAPACITY-1:0]     occupied;
    logic signed [sst_pkg::VAL_W-1:0] value [sst_pkg::CAPACITY];

    sst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .stat  (stat),
        .cmd   (cmd)
    );

    for (genvar i = 0; i < sst_pkg::CAPACITY; i++)
    begin : g_cell
        logic                             left_lt;
        logic signed [sst_pkg::VAL_W-1:0] left_value;
        logic signed [sst_pkg::VAL_W-1:0] right_value;

        assign occupied[i] = (sst_pkg::CNT_W'(i) < cmd.count);

        if (i == 0)
        begin : g_head
            assign left_lt    = 1'b1;
            assign left_value = '0;
        end
        else
        begin : g_body
            assign left_lt    = lt[i-1];
            assign left_value = value[i-1];
        end

        if (i == sst_pkg::CAPACITY - 1)
        begin : g_tail
            assign right_value = '0;
        end
        else
        begin : g_inner
            assign right_value = value[i+1];
        end

        sst_cell u_cell (
            .clk         (clk),
            .occupied    (occupied[i]),
            .cmd         (cmd),
            .left_lt     (left_lt),
            .left_value  (left_value),
            .right_value (right_value),
            .lt          (lt[i]),
            .eq          (eq[i]),
            .value       (value[i])
        );
    end

    assign stat.any_eq   = |eq;
    assign stat.rd_value = value[cmd.rd_idx];

endmodule

// File: rtl/sst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set table cell
// Holds one entry; compares it with the key and shifts with its neighbours.
// ----------------------------------------------------------------------------
module sst_cell (
    input  logic                             clk,
    input  logic                             occupied,
    input  sst_pkg::cmd_t                    cmd,
    input  logic                             left_lt,
    input  logic signed [sst_pkg::VAL_W-1:0] left_value,
    input  logic signed [sst_pkg::VAL_W-1:0] right_value,
    output logic                             lt,
    output logic                             eq,
    output logic signed [sst_pkg::VAL_W-1:0] value
);

    logic signed [sst_pkg::VAL_W-1:0] value_reg;
    logic signed [sst_pkg::VAL_W-1:0] value_next;

    assign lt    = occupied && (value_reg < cmd.key);
    assign eq    = occupied && (value_reg == cmd.key);
    assign value = value_reg;

    // On insert, cells below the insertion point keep their entry, the cell at it takes the key
    // and those above take their left neighbour's; on delete, those from the match up take the right one's.
    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins_en && !lt)
        begin
            value_next = left_lt ? cmd.key : left_value;
        end
        else if (cmd.del_en && !lt)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// File: rtl/sst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set table control
// Decodes requests, keeps the entry count, sequences dumps and holds the
// output register.
// ----------------------------------------------------------------------------
module sst_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    sst_req_if.sink         req,
    sst_rsp_if.source       rsp,
    input  sst_pkg::stat_t  stat,
    output sst_pkg::cmd_t   cmd
);

    sst_pkg::state_t                  state_reg, state_next;
    logic [sst_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [sst_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic                             desc_reg, desc_next;
    logic                             out_valid_reg, out_valid_next;
    sst_pkg::kind_t                   out_kind_reg, out_kind_next;
    logic signed [sst_pkg::VAL_W-1:0] out_value_reg, out_value_next;
    logic                             out_last_reg, out_last_next;

    logic                      slot_free;
    logic                      take;
    logic                      is_dump;
    logic                      full;
    logic                      dump_last;
    logic [sst_pkg::CNT_W-1:0] rev_idx;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign take      = req.valid && req.ready;
    assign is_dump   = (req.op == sst_pkg::OP_DUMP_ASC) || (req.op == sst_pkg::OP_DUMP_DESC);
    assign full      = (count_reg == sst_pkg::CNT_W'(sst_pkg::CAPACITY));
    assign dump_last = (sst_pkg::CNT_W'(idx_reg) == count_reg - sst_pkg::CNT_W'(1));
    assign rev_idx   = count_reg - sst_pkg::CNT_W'(1) - sst_pkg::CNT_W'(idx_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sst_pkg::ST_IDLE:
            begin
                if (take && is_dump && (count_reg != '0))
                begin
                    state_next = sst_pkg::ST_DUMP;
                end
            end
            sst_pkg::ST_DUMP:
            begin
                if (slot_free && dump_last)
                begin
                    state_next = sst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready      = 1'b0;
        cmd.ins_en     = 1'b0;
        cmd.del_en     = 1'b0;
        cmd.key        = req.key_value;
        cmd.rd_idx     = desc_reg ? rev_idx[sst_pkg::IDX_W-1:0] : idx_reg;
        cmd.count      = count_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        desc_next      = desc_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            sst_pkg::ST_IDLE:
            begin
                req.ready = slot_free;
                if (take)
                begin
                    out_value_next = req.key_value;
                    out_last_next  = 1'b1;
                    case (req.op)
                        sst_pkg::OP_INSERT:
                        begin
                            out_valid_next = 1'b1;
                            if (stat.any_eq)
                            begin
                                out_kind_next = sst_pkg::KIND_DUPLICATE;
                            end
                            else if (full)
                            begin
                                out_kind_next = sst_pkg::KIND_FULL;
                            end
                            else
                            begin
                                out_kind_next = sst_pkg::KIND_INSERTED;
                                cmd.ins_en    = 1'b1;
                                count_next    = count_reg + sst_pkg::CNT_W'(1);
                            end
                        end
                        sst_pkg::OP_DELETE:
                        begin
                            out_valid_next = 1'b1;
                            if (stat.any_eq)
                            begin
                                out_kind_next = sst_pkg::KIND_DELETED;
                                cmd.del_en    = 1'b1;
                                count_next    = count_reg - sst_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                out_kind_next = sst_pkg::KIND_NOTFOUND;
                            end
                        end
                        default:
                        begin
                            idx_next  = '0;
                            desc_next = (req.op == sst_pkg::OP_DUMP_DESC);
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = sst_pkg::KIND_EMPTY;
                                out_value_next = '0;
                            end
                        end
                    endcase
                end
            end
            sst_pkg::ST_DUMP:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = sst_pkg::KIND_ENTRY;
                    out_value_next = stat.rd_value;
                    out_last_next  = dump_last;
                    idx_next       = idx_reg + sst_pkg::IDX_W'(1);
                end
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sst_pkg::ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            desc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            desc_reg      <= desc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = out_kind_reg;
    assign rsp.entry_value = out_value_reg;
    assign rsp.last        = out_last_reg;

endmodule

// File: rtl/sst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set table checker
// Port-level assertions on the request and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module sst_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_ready,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input sst_pkg::kind_t                   rsp_kind,
    input logic signed [sst_pkg::VAL_W-1:0] rsp_entry_value,
    input logic                             rsp_last
);

    // A stalled result holds its beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
            && $stable(rsp_entry_value) && $stable(rsp_last))
        else $error("stalled result beat changed");

    // Status results always close their request.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == sst_pkg::KIND_INSERTED || rsp_kind == sst_pkg::KIND_DUPLICATE
            || rsp_kind == sst_pkg::KIND_DELETED || rsp_kind == sst_pkg::KIND_NOTFOUND
            || rsp_kind == sst_pkg::KIND_FULL) |-> rsp_last)
        else $error("status beat without last");

    // An empty dump is a single zero beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind == sst_pkg::KIND_EMPTY |-> rsp_last && rsp_entry_value == '0)
        else $error("malformed empty dump beat");

    // No request is taken while a result is held back.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("request accepted while result stalled");

endmodule

bind sorted_set_table sst_checker u_sst_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_kind        (rsp.kind),
    .rsp_entry_value (rsp.entry_value),
    .rsp_last        (rsp.last)
);
